// ===== sv/stable_merge_sorter_top_defines.svh =====
// assertion helpers shared by the sorter rtl
`ifndef STABLE_MERGE_SORTER_TOP_DEFINES_SVH
`define STABLE_MERGE_SORTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on the block clock
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the block clock
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sms_pkg.sv =====
package sms_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int DATA_W       = 32;
   localparam int STEP_W       = 4;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_LOAD     = 4'd0;
   localparam step_type STEP_WIDTH    = 4'd1;
   localparam step_type STEP_PASS     = 4'd2;
   localparam step_type STEP_RUN      = 4'd3;
   localparam step_type STEP_MERGE    = 4'd4;
   localparam step_type STEP_NEXT_RUN = 4'd5;
   localparam step_type STEP_SWAP     = 4'd6;
   localparam step_type STEP_OUT_INIT = 4'd7;
   localparam step_type STEP_OUT      = 4'd8;
   localparam step_type STEP_CLEAR    = 4'd9;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_WIDTH_INIT,
      OP_PASS_INIT,
      OP_RUN_INIT,
      OP_MERGE,
      OP_NEXT_RUN,
      OP_NEXT_PASS,
      OP_OUT_INIT,
      OP_OUT,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_FINAL,
      COND_WIDTH_DONE,
      COND_RUN_END,
      COND_RUN_MORE,
      COND_OUT_END
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     stay;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         STEP_LOAD:     w = '{OP_LOAD,       COND_FINAL,      STEP_WIDTH,    1'b1};
         STEP_WIDTH:    w = '{OP_WIDTH_INIT, COND_NEVER,      STEP_LOAD,     1'b0};
         STEP_PASS:     w = '{OP_PASS_INIT,  COND_WIDTH_DONE, STEP_OUT_INIT, 1'b0};
         STEP_RUN:      w = '{OP_RUN_INIT,   COND_NEVER,      STEP_LOAD,     1'b0};
         STEP_MERGE:    w = '{OP_MERGE,      COND_RUN_END,    STEP_NEXT_RUN, 1'b1};
         STEP_NEXT_RUN: w = '{OP_NEXT_RUN,   COND_RUN_MORE,   STEP_RUN,      1'b0};
         STEP_SWAP:     w = '{OP_NEXT_PASS,  COND_ALWAYS,     STEP_PASS,     1'b0};
         STEP_OUT_INIT: w = '{OP_OUT_INIT,   COND_NEVER,      STEP_LOAD,     1'b0};
         STEP_OUT:      w = '{OP_OUT,        COND_OUT_END,    STEP_CLEAR,    1'b1};
         STEP_CLEAR:    w = '{OP_CLEAR,      COND_ALWAYS,     STEP_LOAD,     1'b0};
         default:       w = '{OP_CLEAR,      COND_ALWAYS,     STEP_LOAD,     1'b0};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/stable_merge_sorter_top.sv =====
// stable merge sorter
// input beats (start/busy): req_value is taken when start is high and busy is low.
// each beat is stored while busy stays low; beats past CAPACITY are
// dropped and remembered. a beat with req_is_final set closes the set and busy rises.
// the stored set is then sorted ascending by a bottom-up merge sort run by a small
// microcode program: one step word per cycle from a rom, a step counter and jumps.
// each merge pass moves one element per cycle between two ping-pong memories, with
// two registered reads and one write a cycle; a set of n elements takes ceil(log2(n))
// passes.
// results are then streamed one per cycle on rsp_strobe, rsp_end_of_run on the last
// one and rsp_overflowed on all of them if any beat was dropped. after the last result
// a clear step empties the store and busy falls, so the next set may load.
// the receiver cannot stall: every strobe is a taken beat.
// reset (synchronous) empties the store, clears the drop flag and returns to loading.
`include "stable_merge_sorter_top_defines.svh"

module stable_merge_sorter_top
   import sms_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_is_final,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_end_of_run,
   output logic                     rsp_overflowed
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;

   logic signed [DATA_W-1:0] store0_mem [CAPACITY];
   logic signed [DATA_W-1:0] store1_mem [CAPACITY];

   step_type  upc_ff, upc_in;
   ucode_type uword;
   logic      jump;

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [CW-1:0] width_ff, width_in;
   logic          sel_ff, sel_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] a_ff, a_in;
   logic [CW-1:0] b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;
   logic signed [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic [CW:0]   mid_sum, hi_sum;
   logic [CW-1:0] mid_calc, hi_calc;
   logic [CW-1:0] ra, rb, wa;
   logic signed [DATA_W-1:0] wd;
   logic          wr0, wr1;
   logic          take_a;
   logic          has_room;
   logic [CW-1:0] k_next;

   assign uword    = ucode_rom(upc_ff);
   assign has_room = count_ff < CW'(CAPACITY);
   assign k_next   = k_ff + CW'(1);
   assign take_a   = (a_ff < mid_ff) && ((b_ff >= hi_ff) || (rd_a_ff <= rd_b_ff));

   // run bounds clamped to the set size
   always_comb begin
      mid_sum  = {1'b0, lo_ff} + {1'b0, width_ff};
      mid_calc = (mid_sum > {1'b0, count_ff}) ? count_ff : mid_sum[CW-1:0];
      hi_sum   = {1'b0, mid_calc} + {1'b0, width_ff};
      hi_calc  = (hi_sum > {1'b0, count_ff}) ? count_ff : hi_sum[CW-1:0];
   end

   // sequencer
   always_comb begin
      case (uword.cond)
         COND_NEVER:      jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_FINAL:      jump = start && req_is_final;
         COND_WIDTH_DONE: jump = width_ff >= count_ff;
         COND_RUN_END:    jump = k_next == hi_ff;
         COND_RUN_MORE:   jump = hi_ff < count_ff;
         COND_OUT_END:    jump = k_next == count_ff;
         default:         jump = 1'b0;
      endcase
      if (jump) begin
         upc_in = uword.target;
      end else if (uword.stay) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + step_type'(1);
      end
   end

   // datapath
   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      width_in = width_ff;
      sel_in   = sel_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      ra       = a_ff;
      rb       = b_ff;
      wa       = k_ff;
      wd       = take_a ? rd_a_ff : rd_b_ff;
      wr0      = 1'b0;
      wr1      = 1'b0;
      case (uword.op)
         OP_LOAD: begin
            wa = count_ff;
            wd = req_value;
            if (start) begin
               if (has_room) begin
                  wr0      = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         OP_WIDTH_INIT: begin
            width_in = CW'(1);
            sel_in   = 1'b0;
         end
         OP_PASS_INIT: begin
            lo_in = '0;
         end
         OP_RUN_INIT: begin
            mid_in = mid_calc;
            hi_in  = hi_calc;
            a_in   = lo_ff;
            b_in   = mid_calc;
            k_in   = lo_ff;
            ra     = lo_ff;
            rb     = mid_calc;
         end
         OP_MERGE: begin
            wr0  = sel_ff;
            wr1  = !sel_ff;
            k_in = k_next;
            if (take_a) begin
               a_in = a_ff + CW'(1);
            end else begin
               b_in = b_ff + CW'(1);
            end
            ra = a_in;
            rb = b_in;
         end
         OP_NEXT_RUN: begin
            lo_in = hi_ff;
         end
         OP_NEXT_PASS: begin
            width_in = {width_ff[CW-2:0], 1'b0};
            sel_in   = !sel_ff;
         end
         OP_OUT_INIT: begin
            k_in = '0;
            ra   = '0;
         end
         OP_OUT: begin
            k_in = k_next;
            ra   = k_next;
         end
         OP_CLEAR: begin
            count_in = '0;
            drop_in  = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff   <= STEP_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         width_ff <= '0;
         sel_ff   <= 1'b0;
         lo_ff    <= '0;
         mid_ff   <= '0;
         hi_ff    <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         k_ff     <= '0;
      end else begin
         upc_ff   <= upc_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         width_ff <= width_in;
         sel_ff   <= sel_in;
         lo_ff    <= lo_in;
         mid_ff   <= mid_in;
         hi_ff    <= hi_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         k_ff     <= k_in;
      end
   end

   // ping-pong stores, sel_ff names the one holding the current order
   always_ff @(posedge clock) begin
      if (wr0) begin
         store0_mem[wa[AW-1:0]] <= wd;
      end
      if (wr1) begin
         store1_mem[wa[AW-1:0]] <= wd;
      end
      rd_a_ff <= sel_in ? store1_mem[ra[AW-1:0]] : store0_mem[ra[AW-1:0]];
      rd_b_ff <= sel_in ? store1_mem[rb[AW-1:0]] : store0_mem[rb[AW-1:0]];
   end

   assign busy             = upc_ff != STEP_LOAD;
   assign rsp_strobe       = uword.op == OP_OUT;
   assign rsp_sorted_value = rd_a_ff;
   assign rsp_end_of_run   = rsp_strobe && (k_next == count_ff);
   assign rsp_overflowed   = drop_ff;

   `SMS_ASSERT_NOW(a_strobe_busy, rsp_strobe, busy, "result beat while loading")
   `SMS_ASSERT_NEXT(a_gap_after_end, rsp_strobe && rsp_end_of_run, !rsp_strobe,
      "result beat right after end of run")
   `SMS_ASSERT_NEXT(a_load_stays_open, start && !busy && !req_is_final, !busy,
      "busy after a non-final beat")
   `SMS_ASSERT_NOW(a_merge_in_run, uword.op == OP_MERGE, (k_ff < hi_ff) && (k_ff >= lo_ff),
      "merge write outside its run")
   `SMS_ASSERT_NOW(a_ascending,
      rsp_strobe && $past(rsp_strobe) && !$past(rsp_end_of_run),
      $past(rsp_sorted_value) <= rsp_sorted_value, "results out of order")

endmodule
